[rtl/core/zcff_pkg.sv]
// Package for the zero-crossing front finder.
// Holds the transfer payload types, the front codes and the sequencer state types.
// No dependencies.
package zcff_pkg;

    localparam int TEMP_W  = 16;
    localparam int DEPTH_W = 24;
    localparam int PROD_W  = TEMP_W + DEPTH_W;
    localparam int QUO_W   = DEPTH_W;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [1:0] {
        FRONT_NONE   = 2'd0,
        FRONT_THAW   = 2'd1,
        FRONT_FREEZE = 2'd2
    } front_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT,
        ST_EMIT
    } zcff_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_MUL,
        DIV_RUN
    } div_state_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] node_temp;
        logic [DEPTH_W-1:0]       node_depth;
        logic                     last_node;
    } node_item_t;

    typedef struct packed {
        logic [1:0]         front_kind;
        logic [DEPTH_W-1:0] front_depth;
        logic [1:0]         front_slot;
        logic [1:0]         thaw_total;
        logic [1:0]         freeze_total;
        logic               profile_done;
    } result_item_t;

endpackage

[rtl/core/zcff_interp.sv]
// Shared interpolation unit: a multiply step, then a radix-2 restoring divide.
// Computes floor(mul_a * mul_b / divisor), known to fit in 24 bits.
// Depends on zcff_pkg.
module zcff_interp
    import zcff_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [TEMP_W-1:0]  mul_a,
    input  logic [DEPTH_W-1:0] mul_b,
    input  logic [TEMP_W-1:0]  divisor,
    output logic               done,
    output logic [QUO_W-1:0]   quotient
);

    div_state_t             state_reg, state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   done_reg, done_next;

    logic [TEMP_W-1:0]      a_reg;
    logic [DEPTH_W-1:0]     b_reg;
    logic [TEMP_W-1:0]      div_reg;
    logic [TEMP_W-1:0]      rem_reg;
    logic [QUO_W-1:0]       low_reg;
    logic [QUO_W-1:0]       quo_reg;

    logic [PROD_W-1:0]      prod;
    logic [TEMP_W:0]        trial;
    logic [TEMP_W:0]        diff;
    logic                   fits;
    logic [TEMP_W-1:0]      rem_step;

    assign prod     = a_reg * b_reg;
    assign trial    = {rem_reg, low_reg[QUO_W-1]};
    assign fits     = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_step = fits ? diff[TEMP_W-1:0] : trial[TEMP_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    state_next = DIV_MUL;
                end
            end
            DIV_MUL:
            begin
                cnt_next   = DIV_CNT_W'(QUO_W - 1);
                state_next = DIV_RUN;
            end
            DIV_RUN:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == DIV_IDLE && start)
        begin
            a_reg   <= mul_a;
            b_reg   <= mul_b;
            div_reg <= divisor;
        end
        if (state_reg == DIV_MUL)
        begin
            rem_reg <= prod[PROD_W-1:QUO_W];
            low_reg <= prod[QUO_W-1:0];
            quo_reg <= '0;
        end
        else if (state_reg == DIV_RUN)
        begin
            rem_reg <= rem_step;
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/zero_crossing_front_finder_unit.sv]
// Zero-crossing front finder, top level. Uses zcff_pkg and zcff_interp.
// A node with a front waits in ST_WAIT for the 24-step shared divider in zcff_interp;
// a node without a front goes straight to ST_EMIT. The unit takes a new node only
// in ST_IDLE, after the result of the previous node has been loaded for output.
// Reset (rst_n, asynchronous, active low) clears the held node, the front counts,
// the sequencer and the result valid flag.
module zero_crossing_front_finder_unit
    import zcff_pkg::*;
#(
    parameter int MAX_FRONT_COUNT = 3
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         node_valid,
    output logic         node_stall,
    input  node_item_t   node_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item
);

    // Count width holds every value from zero up to the maximum.
    localparam int CNT_W = $clog2(MAX_FRONT_COUNT + 1);

    // Sequencer and profile state.
    zcff_state_t state_reg, state_next;
    logic signed [TEMP_W-1:0] prev_temp_reg, prev_temp_next;
    logic [DEPTH_W-1:0]       prev_depth_reg, prev_depth_next;
    logic                     have_prev_reg, have_prev_next;
    logic [CNT_W-1:0]         thaw_cnt_reg, thaw_cnt_next;
    logic [CNT_W-1:0]         freeze_cnt_reg, freeze_cnt_next;
    logic                     out_valid_reg, out_valid_next;

    // Per-node work registers, loaded on the input transfer, and the output register.
    logic [1:0]         kind_reg;
    logic [1:0]         slot_reg;
    logic [1:0]         thaw_tot_reg;
    logic [1:0]         freeze_tot_reg;
    logic               last_reg;
    logic [DEPTH_W-1:0] zc_reg;
    logic               neg_reg;
    result_item_t       out_reg;

    logic               accept;
    logic               emit;
    logic               thaw_hit;
    logic               freeze_hit;
    logic               front_hit;
    logic signed [TEMP_W-1:0] tc;
    logic [CNT_W-1:0]   thaw_inc;
    logic [CNT_W-1:0]   freeze_inc;
    logic [CNT_W+1:0]   thaw_old_ext, freeze_old_ext, thaw_inc_ext, freeze_inc_ext;

    // Interpolation operands.
    logic signed [TEMP_W:0]  tc_ext;
    logic signed [TEMP_W:0]  dt;
    logic [TEMP_W:0]         tc_abs;
    logic [TEMP_W:0]         dt_abs;
    logic                    dz_neg;
    logic [DEPTH_W-1:0]      dz_abs;
    logic                    div_done;
    logic [QUO_W-1:0]        div_quo;
    logic [DEPTH_W-1:0]      front_depth;

    assign tc     = node_item.node_temp;
    assign accept = node_valid && !node_stall;

    // A thaw front needs a warm current node after a previous node at or below
    // zero; a freeze front is the mirror case. A kind stops being reported
    // once its count reaches the maximum.
    assign thaw_hit = have_prev_reg && (tc > 0) && (prev_temp_reg <= 0)
                      && (thaw_cnt_reg < CNT_W'(MAX_FRONT_COUNT));
    assign freeze_hit = have_prev_reg && !thaw_hit && (tc < 0) && (prev_temp_reg >= 0)
                        && (freeze_cnt_reg < CNT_W'(MAX_FRONT_COUNT));
    assign front_hit = thaw_hit || freeze_hit;

    assign thaw_inc   = thaw_cnt_reg + CNT_W'(thaw_hit);
    assign freeze_inc = freeze_cnt_reg + CNT_W'(freeze_hit);

    // Result fields carry counts modulo four.
    assign thaw_old_ext   = {2'b00, thaw_cnt_reg};
    assign freeze_old_ext = {2'b00, freeze_cnt_reg};
    assign thaw_inc_ext   = {2'b00, thaw_inc};
    assign freeze_inc_ext = {2'b00, freeze_inc};

    // The interpolated offset from the current node has the sign of the depth
    // difference and a magnitude of floor(|tc| * |dz| / |td - tc|), since both
    // front kinds make -tc and td - tc share a sign.
    assign tc_ext = {tc[TEMP_W-1], tc};
    assign dt     = {prev_temp_reg[TEMP_W-1], prev_temp_reg} - tc_ext;
    assign tc_abs = tc_ext[TEMP_W] ? 17'(-tc_ext) : 17'(tc_ext);
    assign dt_abs = dt[TEMP_W] ? 17'(-dt) : 17'(dt);
    assign dz_neg = prev_depth_reg < node_item.node_depth;
    assign dz_abs = dz_neg ? (node_item.node_depth - prev_depth_reg)
                           : (prev_depth_reg - node_item.node_depth);

    zcff_interp u_interp (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && front_hit),
        .mul_a    (tc_abs[TEMP_W-1:0]),
        .mul_b    (dz_abs),
        .divisor  (dt_abs[TEMP_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // The result always lies between the two node depths, so no saturation.
    assign front_depth = (kind_reg == FRONT_NONE) ? '0
                       : (neg_reg ? (zc_reg - div_quo) : (zc_reg + div_quo));

    // The output register frees up when its result is taken, so a new result
    // can be loaded in the same cycle as the previous transfer.
    assign emit = (state_reg == ST_EMIT) && (!out_valid_reg || !result_stall);

    always_comb
    begin
        state_next      = state_reg;
        prev_temp_next  = prev_temp_reg;
        prev_depth_next = prev_depth_reg;
        have_prev_next  = have_prev_reg;
        thaw_cnt_next   = thaw_cnt_reg;
        freeze_cnt_next = freeze_cnt_reg;
        out_valid_next  = out_valid_reg && result_stall;
        node_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                node_stall = 1'b0;
                if (node_valid)
                begin
                    if (node_item.last_node)
                    begin
                        prev_temp_next  = '0;
                        prev_depth_next = '0;
                        have_prev_next  = 1'b0;
                        thaw_cnt_next   = '0;
                        freeze_cnt_next = '0;
                    end
                    else
                    begin
                        prev_temp_next  = tc;
                        prev_depth_next = node_item.node_depth;
                        have_prev_next  = 1'b1;
                        thaw_cnt_next   = thaw_inc;
                        freeze_cnt_next = freeze_inc;
                    end
                    state_next = front_hit ? ST_WAIT : ST_EMIT;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_temp_reg  <= '0;
            prev_depth_reg <= '0;
            have_prev_reg  <= 1'b0;
            thaw_cnt_reg   <= '0;
            freeze_cnt_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            prev_temp_reg  <= prev_temp_next;
            prev_depth_reg <= prev_depth_next;
            have_prev_reg  <= have_prev_next;
            thaw_cnt_reg   <= thaw_cnt_next;
            freeze_cnt_reg <= freeze_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg       <= thaw_hit ? FRONT_THAW : (freeze_hit ? FRONT_FREEZE : FRONT_NONE);
            slot_reg       <= thaw_hit ? thaw_old_ext[1:0]
                                       : (freeze_hit ? freeze_old_ext[1:0] : 2'b00);
            thaw_tot_reg   <= thaw_inc_ext[1:0];
            freeze_tot_reg <= freeze_inc_ext[1:0];
            last_reg       <= node_item.last_node;
            zc_reg         <= node_item.node_depth;
            neg_reg        <= dz_neg;
        end
        if (emit)
        begin
            out_reg.front_kind   <= kind_reg;
            out_reg.front_depth  <= front_depth;
            out_reg.front_slot   <= slot_reg;
            out_reg.thaw_total   <= thaw_tot_reg;
            out_reg.freeze_total <= freeze_tot_reg;
            out_reg.profile_done <= last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

`ifndef SYNTHESIS
    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_WAIT)
        else $error("divider finished outside the wait state");

    // A result without a front carries zero depth and slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.front_kind == FRONT_NONE
        |-> result_item.front_depth == '0 && result_item.front_slot == 2'b00)
        else $error("result without a front carries depth or slot");

    // The last node of a profile clears the held node and both counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        node_valid && !node_stall && node_item.last_node
        |=> !have_prev_reg && thaw_cnt_reg == '0 && freeze_cnt_reg == '0)
        else $error("profile state not cleared after the last node");
`endif

endmodule
